@@ rtl/fixed_point_point_rotator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Point rotator assertion macros
// Shared concurrent assertion forms for the rotator modules.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_POINT_ROTATOR_UNIT_MACROS_SVH
`define FIXED_POINT_POINT_ROTATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Point rotator package
// Types, angle constants and the one-octant sine and cosine tables.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int TABLE_ENTRIES = 46;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FRAC_BITS     = 15;
  localparam int ROUND_BIAS    = 16383;
  localparam int TRUNC_FIX     = (1 << FRAC_BITS) - 1;

  localparam logic signed [10:0] FULL_TURN    = 11'sd360;
  localparam logic signed [10:0] TWO_TURNS    = 11'sd720;
  localparam logic [8:0]         QUARTER_TURN = 9'd90;
  localparam logic [8:0]         HALF_TURN    = 9'd180;
  localparam logic [8:0]         THREE_QUARTS = 9'd270;
  localparam logic [8:0]         LAST_DEGREE  = 9'd359;
  localparam logic [6:0]         EIGHTH_TURN  = 7'd45;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // round(32768 * sin(i deg)) and round(32768 * cos(i deg)), i = 0..45.
  localparam logic [15:0] SIN_TAB [TABLE_ENTRIES] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
    16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847,
    16'd18324, 16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763, 16'd23170
  };

  localparam logic [15:0] COS_TAB [TABLE_ENTRIES] = '{
    16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643,
    16'd32588, 16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166,
    16'd32052, 16'd31928, 16'd31795, 16'd31651, 16'd31499, 16'd31336,
    16'd31164, 16'd30983, 16'd30792, 16'd30592, 16'd30382, 16'd30163,
    16'd29935, 16'd29698, 16'd29452, 16'd29197, 16'd28932, 16'd28660,
    16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166, 16'd26842,
    16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
    16'd24351, 16'd23965, 16'd23571, 16'd23170
  };

  // Point payload that travels alongside the angle and product stages.
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               last;
    logic               zero;
  } point_t;

  // Sine and cosine, scaled by 32768.
  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } trig_t;

endpackage

@@ rtl/fixed_point_point_rotator_unit.sv @@
// ----------------------------------------------------------------------------
// Fixed-point point rotator
// Rotates screen points about a pivot by screen angle plus object angle.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Carries
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | start high, busy low | point, pivot, angle, last flag
//  out_    | output    | out_strobe, 1 cycle  | rotated point, last flag
//  cfg_    | input     | cfg_wr_en            | screen angle in degrees
//
// One item is taken in every clock cycle. Each result passes through the seven
// register stages: three angle stages (reduction, octant fold, table read)
// and four arithmetic stages (multipliers, sums, scaling, pivot add with the
// output register). Reset is synchronous and clears only the valid bits and
// the screen angle register. The receiver cannot stall, so busy is never
// raised and the pipeline always advances.
//
module fixed_point_point_rotator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_pivot_x,
  input  logic signed [15:0] in_pivot_y,
  input  logic signed [9:0]  in_object_angle,
  input  logic               in_last_point,
  output logic               out_strobe,
  output logic signed [17:0] out_rotated_x,
  output logic signed [17:0] out_rotated_y,
  output logic               out_last_out,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data
);

  // The screen angle must only be written while the pipeline is empty (the block
  // itself does not enforce this), so the first stage may read it directly.
  logic [8:0]      screen_angle_r;
  logic            in_accept;
  logic            trig_valid;
  fpr_pkg::trig_t  trig;
  fpr_pkg::point_t point;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_angle_r <= 9'd0;
    end else if (cfg_wr_en) begin
      screen_angle_r <= cfg_wr_data;
    end
  end

  // Every stage moves on each cycle, so the block is never busy.
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Angle reduction, octant fold and sine and cosine lookup.
  fpr_trig u_trig (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_accept),
    .screen_angle (screen_angle_r),
    .object_angle (in_object_angle),
    .point_x      (in_point_x),
    .point_y      (in_point_y),
    .pivot_x      (in_pivot_x),
    .pivot_y      (in_pivot_y),
    .last_point   (in_last_point),
    .out_valid    (trig_valid),
    .out_trig     (trig),
    .out_point    (point)
  );

  // Rotation products, rounding and the pivot offset.
  fpr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_trig   (trig),
    .in_point  (point),
    .out_valid (out_strobe),
    .out_x     (out_rotated_x),
    .out_y     (out_rotated_y),
    .out_last  (out_last_out)
  );

endmodule

@@ rtl/fpr_trig.sv @@
// ----------------------------------------------------------------------------
// Point rotator angle stages
// Reduces the total angle, folds it to an octant and looks up sine and cosine.
// ----------------------------------------------------------------------------
module fpr_trig (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [8:0]          screen_angle,
  input  logic signed [9:0]   object_angle,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  input  logic signed [15:0]  pivot_x,
  input  logic signed [15:0]  pivot_y,
  input  logic                last_point,
  output logic                out_valid,
  output fpr_pkg::trig_t      out_trig,
  output fpr_pkg::point_t     out_point
);

  // Stage 1: angle reduced to 0..359, offsets from the pivot.
  logic               v1_r;
  logic [8:0]         ang1_r, ang1_nxt;
  fpr_pkg::point_t    pt1_r, pt1_nxt;
  logic signed [10:0] sum;
  logic signed [10:0] total;
  logic signed [10:0] wrapped;

  always_comb begin
    sum = $signed({2'b00, screen_angle}) + 11'(object_angle);
    priority if (sum >= fpr_pkg::TWO_TURNS) begin
      total = sum - fpr_pkg::TWO_TURNS;
    end else if (sum >= fpr_pkg::FULL_TURN) begin
      total = sum - fpr_pkg::FULL_TURN;
    end else if (sum <= -fpr_pkg::FULL_TURN) begin
      total = sum + fpr_pkg::FULL_TURN;
    end else begin
      total = sum;
    end
    wrapped      = (total < 0) ? total + fpr_pkg::FULL_TURN : total;
    ang1_nxt     = wrapped[8:0];
    pt1_nxt.px   = point_x;
    pt1_nxt.py   = point_y;
    pt1_nxt.cx   = pivot_x;
    pt1_nxt.cy   = pivot_y;
    pt1_nxt.dx   = 17'(point_x) - 17'(pivot_x);
    pt1_nxt.dy   = 17'(pivot_y) - 17'(point_y);
    pt1_nxt.last = last_point;
    pt1_nxt.zero = (total == 11'sd0);
  end

  // Stage 2: quadrant and folded table index.
  logic               v2_r;
  logic [1:0]         quad2_r, quad2_nxt;
  logic [fpr_pkg::IDX_W-1:0] idx2_r, idx2_nxt;
  logic               swap2_r, swap2_nxt;
  fpr_pkg::point_t    pt2_r;
  logic [8:0]         base;
  logic [8:0]         rem9;
  logic [6:0]         rem;

  always_comb begin
    priority if (ang1_r >= fpr_pkg::THREE_QUARTS) begin
      quad2_nxt = fpr_pkg::QUAD_3;
      base      = fpr_pkg::THREE_QUARTS;
    end else if (ang1_r >= fpr_pkg::HALF_TURN) begin
      quad2_nxt = fpr_pkg::QUAD_2;
      base      = fpr_pkg::HALF_TURN;
    end else if (ang1_r >= fpr_pkg::QUARTER_TURN) begin
      quad2_nxt = fpr_pkg::QUAD_1;
      base      = fpr_pkg::QUARTER_TURN;
    end else begin
      quad2_nxt = fpr_pkg::QUAD_0;
      base      = 9'd0;
    end
    rem9 = ang1_r - base;
    rem  = rem9[6:0];
    if (rem > fpr_pkg::EIGHTH_TURN) begin
      swap2_nxt = 1'b1;
      idx2_nxt  = fpr_pkg::IDX_W'(fpr_pkg::QUARTER_TURN[6:0] - rem);
    end else begin
      swap2_nxt = 1'b0;
      idx2_nxt  = fpr_pkg::IDX_W'(rem);
    end
  end

  // Stage 3: table read and quadrant signs.
  logic               v3_r;
  fpr_pkg::trig_t     tr3_r, tr3_nxt;
  fpr_pkg::point_t    pt3_r;
  logic signed [16:0] s0;
  logic signed [16:0] c0;

  always_comb begin
    if (swap2_r) begin
      s0 = $signed({1'b0, fpr_pkg::COS_TAB[idx2_r]});
      c0 = $signed({1'b0, fpr_pkg::SIN_TAB[idx2_r]});
    end else begin
      s0 = $signed({1'b0, fpr_pkg::SIN_TAB[idx2_r]});
      c0 = $signed({1'b0, fpr_pkg::COS_TAB[idx2_r]});
    end
    unique case (quad2_r)
      fpr_pkg::QUAD_0: begin
        tr3_nxt.s = s0;
        tr3_nxt.c = c0;
      end
      fpr_pkg::QUAD_1: begin
        tr3_nxt.s = c0;
        tr3_nxt.c = -s0;
      end
      fpr_pkg::QUAD_2: begin
        tr3_nxt.s = -s0;
        tr3_nxt.c = -c0;
      end
      default: begin
        tr3_nxt.s = -c0;
        tr3_nxt.c = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ang1_r  <= ang1_nxt;
    pt1_r   <= pt1_nxt;
    quad2_r <= quad2_nxt;
    idx2_r  <= idx2_nxt;
    swap2_r <= swap2_nxt;
    pt2_r   <= pt1_r;
    tr3_r   <= tr3_nxt;
    pt3_r   <= pt2_r;
  end

  assign out_valid = v3_r;
  assign out_trig  = tr3_r;
  assign out_point = pt3_r;

`include "fixed_point_point_rotator_unit_macros.svh"

  `FPR_ASSERT_NOW(a_angle_range, v1_r, ang1_r <= fpr_pkg::LAST_DEGREE, "angle out of range")
  `FPR_ASSERT_NOW(a_fold_below_octant, v2_r && swap2_r,
                  idx2_r < 6'(fpr_pkg::EIGHTH_TURN), "bad fold")
  `FPR_ASSERT_NEXT(a_stage_advance, v2_r, v3_r, "item lost in angle stages")

endmodule

@@ rtl/fpr_mac.sv @@
// ----------------------------------------------------------------------------
// Point rotator product stages
// Four products, rounded sums, truncating scale and the pivot offset.
// ----------------------------------------------------------------------------
module fpr_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fpr_pkg::trig_t     in_trig,
  input  fpr_pkg::point_t    in_point,
  output logic               out_valid,
  output logic signed [17:0] out_x,
  output logic signed [17:0] out_y,
  output logic               out_last
);

  // Stage 1: products.
  logic               v1_r;
  logic signed [33:0] xc1_r, ys1_r, yc1_r, xs1_r;
  fpr_pkg::point_t    pt1_r;

  // Stage 2: rounded sums.
  logic               v2_r;
  logic signed [35:0] nx2_r, ny2_r, nx2_nxt, ny2_nxt;
  fpr_pkg::point_t    pt2_r;

  // Stage 3: divide by 32768, truncating toward zero.
  logic               v3_r;
  logic signed [19:0] qx3_r, qy3_r, qx3_nxt, qy3_nxt;
  logic signed [35:0] ax, ay;
  fpr_pkg::point_t    pt3_r;

  // Stage 4: pivot added back, output register.
  logic               v4_r;
  logic signed [17:0] rx4_r, ry4_r, rx4_nxt, ry4_nxt;
  logic               last4_r;
  logic signed [19:0] sx, sy;

  always_comb begin
    nx2_nxt = 36'(xc1_r) + 36'(ys1_r) + 36'(fpr_pkg::ROUND_BIAS);
    ny2_nxt = 36'(yc1_r) - 36'(xs1_r) + 36'(fpr_pkg::ROUND_BIAS);

    ax = (nx2_r < 0) ? nx2_r + 36'(fpr_pkg::TRUNC_FIX) : nx2_r;
    ay = (ny2_r < 0) ? ny2_r + 36'(fpr_pkg::TRUNC_FIX) : ny2_r;
    qx3_nxt = 20'(ax >>> fpr_pkg::FRAC_BITS);
    qy3_nxt = 20'(ay >>> fpr_pkg::FRAC_BITS);

    sx = 20'(pt3_r.cx) + qx3_r;
    sy = 20'(pt3_r.cy) - qy3_r;
    // A total angle of zero leaves the point where it is.
    rx4_nxt = pt3_r.zero ? 18'(pt3_r.px) : sx[17:0];
    ry4_nxt = pt3_r.zero ? 18'(pt3_r.py) : sy[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    xc1_r   <= in_point.dx * in_trig.c;
    ys1_r   <= in_point.dy * in_trig.s;
    yc1_r   <= in_point.dy * in_trig.c;
    xs1_r   <= in_point.dx * in_trig.s;
    pt1_r   <= in_point;
    nx2_r   <= nx2_nxt;
    ny2_r   <= ny2_nxt;
    pt2_r   <= pt1_r;
    qx3_r   <= qx3_nxt;
    qy3_r   <= qy3_nxt;
    pt3_r   <= pt2_r;
    rx4_r   <= rx4_nxt;
    ry4_r   <= ry4_nxt;
    last4_r <= pt3_r.last;
  end

  assign out_valid = v4_r;
  assign out_x     = rx4_r;
  assign out_y     = ry4_r;
  assign out_last  = last4_r;

`include "fixed_point_point_rotator_unit_macros.svh"

  `FPR_ASSERT_NOW(a_latency, v4_r, $past(v1_r, 3), "result without an item")
  `FPR_ASSERT_NOW(a_sum_range, v2_r,
                  (nx2_r < 36'sh200000000) && (nx2_r > -36'sh200000000), "sum overflow")
  `FPR_ASSERT_NEXT(a_stage_advance, v1_r, v2_r, "item lost in product stages")

endmodule
